>>> design/distributed_mutex_node_defines.svh
// ----------------------------------------------------------------------------
// Distributed mutex node assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DISTRIBUTED_MUTEX_NODE_DEFINES_SVH
`define DISTRIBUTED_MUTEX_NODE_DEFINES_SVH

// Same-cycle implication.
`define DMN_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DMN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/dmn_pkg.sv
// ----------------------------------------------------------------------------
// Distributed mutex node package
// Word types, codes and the command and status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package dmn_pkg;

	typedef enum logic [1:0] {
		OP_ACQUIRE = 2'd0,
		OP_RELEASE = 2'd1,
		OP_MESSAGE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		MSG_REPLY   = 2'd0,
		MSG_REQUEST = 2'd1
	} msg_kind_t;

	typedef enum logic [1:0] {
		OUT_REQUEST = 2'd0,
		OUT_REPLY   = 2'd1,
		OUT_ENTRY   = 2'd2
	} out_kind_t;

	typedef enum logic [1:0] {
		DEST_INDEX  = 2'd0,
		DEST_SENDER = 2'd1,
		DEST_SELF   = 2'd2
	} dest_sel_t;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 5;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_ID    = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_NODE_COUNT = 1'b1;

	localparam logic [3:0] NODE_ID_RESET    = 4'd1;
	localparam logic [4:0] NODE_COUNT_RESET = 5'd2;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  msg_kind;
		logic [3:0]  sender;
		logic [15:0] msg_time;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [3:0]  dest;
		logic [15:0] out_time;
		logic        last;
	} out_word_t;

	typedef struct packed {
		logic      load_in;
		logic      acq_start;
		logic      rel_start;
		logic      clk_max;
		logic      clk_inc;
		logic      idx_inc;
		logic      inc_replies;
		logic      set_defer;
		logic      clr_defer;
		logic      emit;
		out_kind_t emit_kind;
		dest_sel_t dest_sel;
		logic      time_next;
		logic      emit_last;
	} ctl_cmd_t;

	typedef struct packed {
		op_t       opcode;
		msg_kind_t msg_kind;
		logic      n_one;
		logic      idx_is_me;
		logic      idx_is_last_peer;
		logic      def_bit;
		logic      def_last;
		logic      def_empty;
		logic      reply_counts;
		logic      reply_done;
		logic      is_peer;
		logic      answer_now;
		logic      slot_free;
	} dp_sts_t;

endpackage

>>> design/dmn_ctrl.sv
// ----------------------------------------------------------------------------
// Distributed mutex node controller
// Sequences acquire, release and message handling one word at a time and
// drives the datapath with per-cycle commands.
// ----------------------------------------------------------------------------
`include "distributed_mutex_node_defines.svh"

module dmn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  dmn_pkg::dp_sts_t  sts,
	output dmn_pkg::ctl_cmd_t ctl
);
	import dmn_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ACQ_SCAN,
		ST_ACQ_ENTRY,
		ST_REL_SCAN,
		ST_MSG_ACT
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   ready_q;

	assign cmd_ready = ready_q;

	always_comb begin
		ctl = '0;
		ctl.load_in = cmd_valid && ready_q;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ctl.load_in) begin
					state_nxt = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (sts.opcode)
					OP_ACQUIRE: begin
						ctl.acq_start = 1'b1;
						state_nxt = sts.n_one ? ST_ACQ_ENTRY : ST_ACQ_SCAN;
					end
					OP_RELEASE: begin
						ctl.rel_start = 1'b1;
						state_nxt = ST_REL_SCAN;
					end
					OP_MESSAGE: begin
						ctl.clk_max = 1'b1;
						state_nxt = ST_MSG_ACT;
					end
					default: state_nxt = ST_IDLE;
				endcase
			end
			ST_ACQ_SCAN: begin
				if (sts.idx_is_me) begin
					ctl.idx_inc = 1'b1;
				end else if (sts.slot_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = OUT_REQUEST;
					ctl.dest_sel  = DEST_INDEX;
					ctl.emit_last = sts.idx_is_last_peer;
					ctl.idx_inc   = 1'b1;
					if (sts.idx_is_last_peer) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_ACQ_ENTRY: begin
				if (sts.slot_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = OUT_ENTRY;
					ctl.dest_sel  = DEST_SELF;
					ctl.emit_last = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_REL_SCAN: begin
				if (sts.def_empty) begin
					state_nxt = ST_IDLE;
				end else if (!sts.def_bit) begin
					ctl.idx_inc = 1'b1;
				end else if (sts.slot_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = OUT_REPLY;
					ctl.dest_sel  = DEST_INDEX;
					ctl.time_next = 1'b1;
					ctl.emit_last = sts.def_last;
					ctl.clk_inc   = 1'b1;
					ctl.clr_defer = 1'b1;
					ctl.idx_inc   = 1'b1;
					if (sts.def_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_MSG_ACT: begin
				case (sts.msg_kind)
					MSG_REPLY: begin
						if (!sts.reply_counts) begin
							state_nxt = ST_IDLE;
						end else if (!sts.reply_done) begin
							ctl.inc_replies = 1'b1;
							state_nxt = ST_IDLE;
						end else if (sts.slot_free) begin
							ctl.inc_replies = 1'b1;
							ctl.emit        = 1'b1;
							ctl.emit_kind   = OUT_ENTRY;
							ctl.dest_sel    = DEST_SELF;
							ctl.emit_last   = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
					MSG_REQUEST: begin
						if (!sts.is_peer) begin
							state_nxt = ST_IDLE;
						end else if (!sts.answer_now) begin
							ctl.set_defer = 1'b1;
							state_nxt = ST_IDLE;
						end else if (sts.slot_free) begin
							ctl.emit      = 1'b1;
							ctl.emit_kind = OUT_REPLY;
							ctl.dest_sel  = DEST_SENDER;
							ctl.time_next = 1'b1;
							ctl.emit_last = 1'b1;
							ctl.clk_inc   = 1'b1;
							state_nxt = ST_IDLE;
						end
					end
					default: state_nxt = ST_IDLE;
				endcase
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_nxt;
			ready_q <= (state_nxt == ST_IDLE);
		end
	end

	`DMN_ASSERT_NOW(a_emit_slot_free, ctl.emit, sts.slot_free, "Word emitted into an occupied slot.")
	`DMN_ASSERT_NEXT(a_last_ends_item, ctl.emit && ctl.emit_last, cmd_ready, "Final word did not end the item.")
	`DMN_ASSERT_NEXT(a_accept_dispatch, ctl.load_in, !cmd_ready && state_q == ST_DISPATCH, "Accepted word not dispatched.")

endmodule

>>> design/dmn_dp.sv
// ----------------------------------------------------------------------------
// Distributed mutex node datapath
// Lamport clock, request state, deferred set, scan index, configuration and
// the output word register.
// ----------------------------------------------------------------------------
`include "distributed_mutex_node_defines.svh"

module dmn_dp #(
	parameter int MAX_NODES = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dmn_pkg::ctl_cmd_t                    ctl,
	output dmn_pkg::dp_sts_t                     sts,
	input  dmn_pkg::in_word_t                    cmd_word,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output dmn_pkg::out_word_t                   rsp_word,
	input  logic                                 cfg_we,
	input  logic [dmn_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dmn_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import dmn_pkg::*;

	localparam int IW = $clog2(MAX_NODES);
	localparam int NW = $clog2(MAX_NODES + 1);
	localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

	logic [TIME_BITS-1:0] clock_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic                 requesting_q;
	logic [IW-1:0]        replies_q;
	logic [MAX_NODES-1:0] deferred_q;
	logic [IW-1:0]        idx_q;
	in_word_t             in_q;
	logic [3:0]           node_id_q;
	logic [4:0]           node_count_q;
	logic                 out_valid_q;
	out_word_t            out_word_q;

	logic [NW-1:0]        n_eff;
	logic [IW-1:0]        me;
	logic [IW-1:0]        needed;
	logic [NW-1:0]        last_peer;
	logic [TIME_BITS-1:0] clock_inc;
	logic [TIME_BITS-1:0] clock_mx;
	logic [TIME_BITS-1:0] clock_mx_inc;
	logic [MAX_NODES-1:0] sender_oh;
	logic [MAX_NODES-1:0] idx_oh;
	logic [TIME_BITS-1:0] emit_time;
	logic [3:0]           emit_dest;

	always_comb begin
		if (32'(node_count_q) > MAX_NODES) begin
			n_eff = NW'(MAX_NODES);
		end else if (node_count_q == 5'd0) begin
			n_eff = NW'(1);
		end else begin
			n_eff = NW'(node_count_q);
		end
		if (32'(node_id_q) < 32'(n_eff)) begin
			me = IW'(node_id_q);
		end else begin
			me = IW'(n_eff - NW'(1));
		end
		needed = IW'(n_eff - NW'(1));
		if (NW'(me) == n_eff - NW'(1)) begin
			last_peer = n_eff - NW'(2);
		end else begin
			last_peer = n_eff - NW'(1);
		end
	end

	assign clock_inc    = (clock_q == TIME_TOP) ? clock_q : clock_q + TIME_BITS'(1);
	assign clock_mx     = (TIME_BITS'(in_q.msg_time) > clock_q) ?
		TIME_BITS'(in_q.msg_time) : clock_q;
	assign clock_mx_inc = (clock_mx == TIME_TOP) ? clock_mx : clock_mx + TIME_BITS'(1);

	always_comb begin
		for (int i = 0; i < MAX_NODES; i++) begin
			sender_oh[i] = (32'(in_q.sender) == i);
			idx_oh[i]    = (32'(idx_q) == i);
		end
	end

	always_comb begin
		sts.opcode           = op_t'(in_q.opcode);
		sts.msg_kind         = msg_kind_t'(in_q.msg_kind);
		sts.n_one            = (n_eff == NW'(1));
		sts.idx_is_me        = (idx_q == me);
		sts.idx_is_last_peer = (NW'(idx_q) == last_peer);
		sts.def_bit          = deferred_q[idx_q];
		sts.def_last         = ((deferred_q & ~idx_oh) == '0);
		sts.def_empty        = (deferred_q == '0);
		sts.reply_counts     = requesting_q && (replies_q < needed);
		sts.reply_done       = ((replies_q + IW'(1)) == needed);
		sts.is_peer          = (32'(in_q.sender) < 32'(n_eff)) &&
			(32'(in_q.sender) != 32'(me));
		sts.answer_now       = !requesting_q ||
			(TIME_BITS'(in_q.msg_time) < stamp_q) ||
			((TIME_BITS'(in_q.msg_time) == stamp_q) && (in_q.sender < node_id_q));
		sts.slot_free        = !out_valid_q || rsp_ready;
	end

	always_comb begin
		case (ctl.dest_sel)
			DEST_INDEX:  emit_dest = 4'(idx_q);
			DEST_SENDER: emit_dest = in_q.sender;
			DEST_SELF:   emit_dest = node_id_q;
			default:     emit_dest = node_id_q;
		endcase
		emit_time = ctl.time_next ? clock_inc : clock_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q      <= '0;
			stamp_q      <= '0;
			requesting_q <= 1'b0;
			replies_q    <= '0;
			deferred_q   <= '0;
			node_id_q    <= NODE_ID_RESET;
			node_count_q <= NODE_COUNT_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_ID:    node_id_q <= cfg_data[3:0];
					CFG_NODE_COUNT: node_count_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.acq_start) begin
				requesting_q <= 1'b1;
				replies_q    <= '0;
				clock_q      <= clock_inc;
				stamp_q      <= clock_inc;
			end else if (ctl.clk_max) begin
				clock_q <= clock_mx_inc;
			end else if (ctl.clk_inc) begin
				clock_q <= clock_inc;
			end
			if (ctl.rel_start) begin
				requesting_q <= 1'b0;
			end
			if (ctl.inc_replies) begin
				replies_q <= replies_q + IW'(1);
			end
			if (ctl.set_defer) begin
				deferred_q <= deferred_q | sender_oh;
			end else if (ctl.clr_defer) begin
				deferred_q <= deferred_q & ~idx_oh;
			end
			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			in_q <= cmd_word;
		end
		if (ctl.acq_start || ctl.rel_start) begin
			idx_q <= '0;
		end else if (ctl.idx_inc) begin
			idx_q <= idx_q + IW'(1);
		end
		if (ctl.emit) begin
			out_word_q.out_kind <= ctl.emit_kind;
			out_word_q.dest     <= emit_dest;
			out_word_q.out_time <= 16'(emit_time);
			out_word_q.last     <= ctl.emit_last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_word  = out_word_q;

	`DMN_ASSERT_NEXT(a_acq_state, ctl.acq_start, requesting_q && replies_q == '0 && stamp_q == clock_q, "Acquire did not arm the request.")
	`DMN_ASSERT_NEXT(a_defer_set, ctl.set_defer, deferred_q != '0, "Deferred request was lost.")
	`DMN_ASSERT_NEXT(a_reply_stamp, ctl.emit && ctl.time_next, rsp_word.out_time == 16'(clock_q), "Reply stamp differs from the clock.")

endmodule

>>> design/distributed_mutex_node.sv
// ----------------------------------------------------------------------------
// Distributed mutex node
// One node of a Ricart-Agrawala mutual exclusion group with a saturating
// Lamport clock, built as a controller and a datapath.
// ----------------------------------------------------------------------------
// An accepted word is latched and dispatched in the next cycle. A received
// message is handled in steps: latch, clock update, then answer, defer or
// count the reply. An acquire scans the node indexes up to the last peer,
// emitting one request word per peer (or one entry word when the node is
// alone). A release scans the indexes up to the highest deferred peer,
// emitting one reply word per deferred peer in ascending order, and emits
// nothing when nothing is deferred. A stalled output holds the item. A new
// word is accepted as soon as the previous item has emitted its final word,
// even while that word still waits in the output register.
`include "distributed_mutex_node_defines.svh"

module distributed_mutex_node #(
	parameter int MAX_NODES = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_ready,
	input  dmn_pkg::in_word_t                    cmd_word,
	output logic                                 rsp_valid,
	input  logic                                 rsp_ready,
	output dmn_pkg::out_word_t                   rsp_word,
	input  logic                                 cfg_we,
	input  logic [dmn_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [dmn_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
	import dmn_pkg::*;

	ctl_cmd_t ctl;
	dp_sts_t  sts;

	dmn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	dmn_dp #(
		.MAX_NODES (MAX_NODES),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

>>> dv/dmn_checker.sv
// ----------------------------------------------------------------------------
// Distributed mutex node checker
// Watches the command, response and configuration ports of the node. It keeps
// its own copy of the Lamport clock, request state and deferred set, predicts
// every response word, and compares each accepted response word field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module dmn_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  logic                               cmd_ready,
	input  dmn_pkg::in_word_t                  cmd_word,
	input  logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  dmn_pkg::out_word_t                 rsp_word,
	input  logic                               cfg_we,
	input  logic [dmn_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dmn_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 pending,
	output int                                 fails
);
	import dmn_pkg::*;

	localparam int          PEER_LIMIT = 16;
	localparam logic [15:0] STAMP_TOP  = 16'hFFFF;
	localparam int          PRINT_CAP  = 40;

	logic [3:0]  self_id;
	logic [4:0]  group_size;
	logic [15:0] lamport;
	logic        wants_entry;
	logic [15:0] own_stamp;
	logic [4:0]  grants;
	logic [15:0] held_back;
	out_word_t   owed_words[$];
	out_word_t   burst[$];
	out_word_t   want;

	function automatic logic [15:0] tick(logic [15:0] t);
		return (t == STAMP_TOP) ? t : t + 16'd1;
	endfunction

	task automatic report(string msg);
		fails++;
		if (fails <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic add_word(out_kind_t kind, logic [3:0] to, logic [15:0] stamp);
		out_word_t w;
		w.out_kind = kind;
		w.dest     = to;
		w.out_time = stamp;
		w.last     = 1'b0;
		burst.push_back(w);
	endtask

	task automatic advance(in_word_t w);
		int  n;
		int  me;
		int  needed;
		logic answer;
		burst.delete();
		n = (group_size > PEER_LIMIT) ? PEER_LIMIT : ((group_size == 0) ? 1 : int'(group_size));
		me = (self_id < n) ? int'(self_id) : n - 1;
		needed = n - 1;
		case (w.opcode)
			OP_ACQUIRE: begin
				wants_entry = 1'b1;
				grants = '0;
				lamport = tick(lamport);
				own_stamp = lamport;
				for (int i = 0; i < n; i++)
					if (i != me)
						add_word(OUT_REQUEST, 4'(i), lamport);
				if (needed == 0)
					add_word(OUT_ENTRY, self_id, lamport);
			end
			OP_RELEASE: begin
				wants_entry = 1'b0;
				for (int i = 0; i < PEER_LIMIT; i++) begin
					if (held_back[i]) begin
						lamport = tick(lamport);
						add_word(OUT_REPLY, 4'(i), lamport);
					end
				end
				held_back = '0;
			end
			OP_MESSAGE: begin
				lamport = tick((w.msg_time > lamport) ? w.msg_time : lamport);
				if (w.msg_kind == MSG_REPLY) begin
					if (wants_entry && grants < needed) begin
						grants++;
						if (grants == needed)
							add_word(OUT_ENTRY, self_id, lamport);
					end
				end else if (w.msg_kind == MSG_REQUEST) begin
					if (w.sender < n && w.sender != me) begin
						answer = !wants_entry || w.msg_time < own_stamp ||
							(w.msg_time == own_stamp && w.sender < self_id);
						if (answer) begin
							lamport = tick(lamport);
							add_word(OUT_REPLY, w.sender, lamport);
						end else begin
							held_back[w.sender] = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		if (burst.size() > 0)
			burst[burst.size()-1].last = 1'b1;
		foreach (burst[i])
			owed_words.push_back(burst[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id     = NODE_ID_RESET;
			group_size  = NODE_COUNT_RESET;
			lamport     = '0;
			wants_entry = 1'b0;
			own_stamp   = '0;
			grants      = '0;
			held_back   = '0;
			owed_words.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_NODE_ID)
					self_id = cfg_data[3:0];
				else if (cfg_index == CFG_NODE_COUNT)
					group_size = cfg_data[4:0];
			end
			if (rsp_valid && rsp_ready) begin
				if (owed_words.size() == 0) begin
					report($sformatf("unexpected word kind %0d dest %0d stamp %0d",
						rsp_word.out_kind, rsp_word.dest, rsp_word.out_time));
				end else begin
					want = owed_words.pop_front();
					if (rsp_word.out_kind != want.out_kind)
						report($sformatf("out_kind %0d, expected %0d",
							rsp_word.out_kind, want.out_kind));
					if (rsp_word.dest != want.dest)
						report($sformatf("dest %0d, expected %0d", rsp_word.dest, want.dest));
					if (rsp_word.out_time != want.out_time)
						report($sformatf("out_time %0d, expected %0d",
							rsp_word.out_time, want.out_time));
					if (rsp_word.last != want.last)
						report($sformatf("last %0b, expected %0b", rsp_word.last, want.last));
				end
			end
			if (cmd_valid && cmd_ready)
				advance(cmd_word);
			pending <= owed_words.size();
		end
	end

endmodule

>>> dv/tb_distributed_mutex_node.sv
// ----------------------------------------------------------------------------
// Distributed mutex node testbench
// Drives acquire, release and received-message words into the node under
// random idling on both channels, across several node id and group size
// settings. A checker beside the node predicts and compares every response
// word; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_distributed_mutex_node;
	import dmn_pkg::*;

	localparam logic [1:0] OP_IGNORED     = 2'd3;
	localparam logic [1:0] MSG_CLOCK_ONLY = 2'd2;
	localparam logic [1:0] MSG_SPARE      = 2'd3;
	localparam int         PAUSE_CYCLES   = 40;
	localparam int         HOLD_CYCLES    = 400;
	localparam int         RANDOM_ITEMS   = 420;
	localparam int         PHASES         = 6;

	logic                      clk;
	logic                      arst_n;
	logic                      cmd_valid;
	logic                      cmd_ready;
	in_word_t                  cmd_word;
	logic                      rsp_valid;
	logic                      rsp_ready;
	out_word_t                 rsp_word;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        pending;
	int                        fails;

	logic [15:0] seen_stamp = '0;
	logic [15:0] seen_request = '0;
	bit          hold_req = 1'b0;
	bit          steady = 1'b0;
	int          words_sent = 0;
	int          group_n = 2;
	int          self_pos = 1;

	distributed_mutex_node u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dmn_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pending   (pending),
		.fails     (fails)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Stamps near the node's own request stamp make the tie breaks happen.
	function automatic logic [15:0] pick_stamp();
		int r;
		int v;
		r = $urandom_range(0, 99);
		if (r < 35)
			v = int'(seen_request) + int'($urandom_range(0, 2)) - 1;
		else if (r < 70)
			v = int'(seen_stamp) + int'($urandom_range(0, 24));
		else if (r < 95)
			v = $urandom_range(0, 255);
		else
			v = $urandom_range(0, 49151);
		if (v < 0)
			v = 0;
		if (v > 60000)
			v = 60000;
		return 16'(v);
	endfunction

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			seen_stamp <= rsp_word.out_time;
			if (rsp_word.out_kind == OUT_REQUEST)
				seen_request <= rsp_word.out_time;
		end
	end

	initial begin
		int g;
		rsp_ready <= 1'b0;
		forever begin
			if (hold_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			rsp_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			g = steady ? 0 : pick_gap();
			if (g > 0) begin
				rsp_ready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	task automatic send_op(logic [1:0] op, logic [1:0] kind, logic [3:0] who,
		logic [15:0] stamp);
		int g;
		g = steady ? 0 : pick_gap();
		if (g > 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= '{opcode: op, msg_kind: kind, sender: who, msg_time: stamp};
		do @(posedge clk); while (!cmd_ready);
		if (op != OP_IGNORED)
			words_sent++;
	endtask

	task automatic send_local(logic [1:0] op);
		send_op(op, 2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), pick_stamp());
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (PAUSE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(logic [3:0] id, logic [4:0] count);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_NODE_ID;
		cfg_data <= 5'(id);
		@(posedge clk);
		cfg_index <= CFG_NODE_COUNT;
		cfg_data <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		group_n = (count > 16) ? 16 : ((count == 0) ? 1 : int'(count));
		self_pos = (id < group_n) ? int'(id) : group_n - 1;
	endtask

	function automatic logic [3:0] peer_at(int k);
		return 4'((k < self_pos) ? k : k + 1);
	endfunction

	function automatic logic [3:0] pick_requester();
		if (group_n > 1 && $urandom_range(0, 99) < 85)
			return peer_at($urandom_range(0, group_n - 2));
		return 4'($urandom_range(0, 15));
	endfunction

	// One acquire, the replies of the peers with requests mixed in, then a
	// release; now and then the round is cut short.
	task automatic run_round();
		send_local(OP_ACQUIRE);
		for (int k = 0; k < group_n - 1; k++) begin
			if ($urandom_range(0, 3) == 0)
				send_op(OP_MESSAGE, MSG_REQUEST, pick_requester(), pick_stamp());
			if ($urandom_range(0, 19) == 0)
				break;
			send_op(OP_MESSAGE, MSG_REPLY, peer_at(k), pick_stamp());
		end
		if ($urandom_range(0, 2) == 0)
			send_op(OP_MESSAGE, MSG_REQUEST, pick_requester(), pick_stamp());
		if ($urandom_range(0, 9) != 0)
			send_local(OP_RELEASE);
	endtask

	task automatic send_noise();
		send_op(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
			4'($urandom_range(0, 15)), pick_stamp());
	endtask

	initial begin
		int phase_end;
		cmd_valid <= 1'b0;
		cmd_word <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(4'd2, 5'd4);
		send_op(OP_ACQUIRE, MSG_SPARE, 4'd15, 16'hFFFF);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd3, 16'd1);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd0, 16'd1);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd1, 16'd0);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd2, 16'd5);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd9, 16'd5);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd1, 16'd0);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd3, 16'd0);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_CLOCK_ONLY, 4'd5, 16'd20);
		send_op(OP_MESSAGE, MSG_SPARE, 4'd5, 16'd0);
		send_op(OP_IGNORED, MSG_REQUEST, 4'd1, 16'd0);
		send_op(OP_RELEASE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_RELEASE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd1, 16'd3);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_RELEASE, MSG_REPLY, 4'd0, 16'd0);
		set_config(4'd7, 5'd0);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd0, 16'd0);
		set_config(4'd15, 5'd31);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd15, 16'd0);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd0, 16'd0);
		set_config(4'd9, 5'd5);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd3, 16'd900);
		send_op(OP_RELEASE, MSG_REPLY, 4'd0, 16'd0);

		words_sent = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_config(4'd0, 5'd16);
				1: set_config(4'd15, 5'd2);
				2: set_config(4'd6, 5'd31);
				3: set_config(4'd12, 5'd3);
				default: set_config(4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
			endcase
			if (ph == 0) begin
				steady = 1'b1;
				hold_req = 1'b1;
				repeat (6)
					send_local(OP_ACQUIRE);
				steady = 1'b0;
			end
			steady = (ph == 1);
			phase_end = (RANDOM_ITEMS * (ph + 1)) / PHASES;
			while (words_sent < phase_end) begin
				if ($urandom_range(0, 99) < 75)
					run_round();
				else
					send_noise();
			end
			steady = 1'b0;
		end

		// The clock saturates for good, so the top of the clock comes last.
		set_config(4'd1, 5'd3);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_CLOCK_ONLY, 4'd0, 16'hFFFF);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd0, 16'hFFFF);
		send_op(OP_ACQUIRE, MSG_REPLY, 4'd0, 16'd0);
		send_op(OP_MESSAGE, MSG_REQUEST, 4'd2, 16'hFFFF);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd0, 16'hFFFF);
		send_op(OP_MESSAGE, MSG_REPLY, 4'd2, 16'hFFFF);
		send_op(OP_RELEASE, MSG_REPLY, 4'd0, 16'd0);

		settle();
		@(negedge clk);
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/dmn_pkg.sv
design/dmn_ctrl.sv
design/dmn_dp.sv
design/distributed_mutex_node.sv
dv/dmn_checker.sv
dv/tb_distributed_mutex_node.sv
